[rtl/core/sorted_table_binary_search_assert.svh]
// Assertion macros for the sorted table search block.
// Used by the port checker; expects clk and arst_n in the including scope.
`ifndef SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SBS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbs: next-cycle check failed");

`endif

[rtl/core/sbs_pkg.sv]
// Shared constants and types for the sorted table search block.
// No dependencies; imported by all but the RAM and macros header.
package sbs_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Field widths
	localparam int VALUE_W   = 64;
	localparam int POS_W     = 10;
	localparam int ENTRIES_W = 11;

	// Common width for mixing positions, counts and addresses
	localparam int WIDE_W = (ENTRIES_W > TBL_AW + 1) ? ENTRIES_W : TBL_AW + 1;

	localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = ENTRIES_W'(1024);

	// Request kinds
	typedef enum logic {
		REQ_WRITE  = 1'b0,
		REQ_SEARCH = 1'b1
	} sbs_req_type_t;

	// Finished search handed from the controller to the output register
	typedef struct packed {
		logic             valid;
		logic             found;
		logic [POS_W-1:0] pos;
	} sbs_result_t;

endpackage

[rtl/core/sbs_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on sbs_pkg for field widths.
interface sbs_req_if import sbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [POS_W-1:0]          position;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, req_type, position, value, input ready);
	modport sink (input valid, req_type, position, value, output ready);
endinterface

interface sbs_rsp_if import sbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] match_position;

	modport source (output valid, found, match_position, input ready);
	modport sink (input valid, found, match_position, output ready);
endinterface

[rtl/core/sbs_table_ram.sv]
// Single-port synchronous RAM with registered read data.
// Standalone; holds the sorted table entries.
module sbs_table_ram #(
	parameter int DATA_W = 64,
	parameter int ADDR_W = 10,
	parameter int DEPTH  = 1024
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write, or else read into the read-data register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/sbs_ctrl.sv]
// Request sequencer: table writes and the bisection probe loop.
// Depends on sbs_pkg and sbs_req_if; drives the table RAM port.
module sbs_ctrl import sbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sbs_req_if.sink              req,
	input  logic [ENTRIES_W-1:0] entries,
	input  logic                 slot_free,
	output sbs_result_t          res,
	output logic                 ram_we,
	output logic [TBL_AW-1:0]    ram_addr,
	output logic [VALUE_W-1:0]   ram_wdata,
	input  logic [VALUE_W-1:0]   ram_rdata
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_HOLD   = 3'b100
	} sbs_state_t;

	sbs_state_t          state_q, state_d;
	logic [TBL_AW-1:0]   lo_q, lo_d;
	logic [TBL_AW-1:0]   hi_q, hi_d;
	logic [TBL_AW-1:0]   mid_q, mid_d;
	logic [VALUE_W-1:0]  key_q;
	logic                hold_found_q;
	logic [POS_W-1:0]    hold_pos_q;

	logic                accept;
	logic [WIDE_W-1:0]   ent_w, depth_w, n_w, n_m1_w, pos_w, mid_w;
	logic                n_zero, wr_ok;
	logic [TBL_AW-1:0]   mid0, hi0;
	logic [TBL_AW:0]     up_sum, dn_sum;
	logic [TBL_AW-1:0]   mid_up, mid_dn;
	logic                probe_eq, probe_lt;
	logic                fin, fin_found;
	logic [POS_W-1:0]    fin_pos;

	assign accept = req.valid && req.ready;

	// Clamp the searched count to the table depth and seed the first probe
	assign ent_w   = WIDE_W'(entries);
	assign depth_w = WIDE_W'(TABLE_DEPTH);
	assign n_w     = (ent_w > depth_w) ? depth_w : ent_w;
	assign n_zero  = (n_w == '0);
	assign n_m1_w  = n_w - WIDE_W'(1);
	assign hi0     = n_m1_w[TBL_AW-1:0];
	assign mid0    = n_m1_w[TBL_AW:1];

	// Drop writes beyond the table
	assign pos_w = WIDE_W'(req.position);
	assign wr_ok = (pos_w < depth_w);

	// Next midpoints for both outcomes, ready before the compare settles
	assign up_sum = {1'b0, mid_q} + {1'b0, hi_q} + (TBL_AW+1)'(1);
	assign dn_sum = {1'b0, lo_q} + {1'b0, mid_q} - (TBL_AW+1)'(1);
	assign mid_up = up_sum[TBL_AW:1];
	assign mid_dn = dn_sum[TBL_AW:1];

	// Compare the probe against the key
	assign probe_eq = (ram_rdata == key_q);
	assign probe_lt = ($signed(ram_rdata) < $signed(key_q));
	assign mid_w    = WIDE_W'(mid_q);

	// Sequence writes and probes
	always_comb begin
		state_d   = state_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		ram_we    = 1'b0;
		ram_addr  = mid_q;
		ram_wdata = req.value;
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_pos   = '0;
		req.ready = (state_q == ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_WRITE) begin
						ram_we   = wr_ok;
						ram_addr = pos_w[TBL_AW-1:0];
					end else if (n_zero) begin
						fin = 1'b1;
					end else begin
						lo_d     = '0;
						hi_d     = hi0;
						mid_d    = mid0;
						ram_addr = mid0;
						state_d  = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (probe_eq) begin
					fin       = 1'b1;
					fin_found = 1'b1;
					fin_pos   = mid_w[POS_W-1:0];
				end else if (probe_lt) begin
					if (mid_q == hi_q) begin
						fin = 1'b1;
					end else begin
						lo_d     = mid_q + TBL_AW'(1);
						mid_d    = mid_up;
						ram_addr = mid_up;
					end
				end else begin
					if (mid_q == lo_q) begin
						fin = 1'b1;
					end else begin
						hi_d     = mid_q - TBL_AW'(1);
						mid_d    = mid_dn;
						ram_addr = mid_dn;
					end
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Hand off the result, or hold it while the output slot is full
		if (fin) begin
			state_d = slot_free ? ST_IDLE : ST_HOLD;
		end
	end

	assign res.valid = fin || (state_q == ST_HOLD);
	assign res.found = (state_q == ST_HOLD) ? hold_found_q : fin_found;
	assign res.pos   = (state_q == ST_HOLD) ? hold_pos_q : fin_pos;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Search bounds, key and held result
	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		if (accept) begin
			key_q <= req.value;
		end
		if (fin) begin
			hold_found_q <= fin_found;
			hold_pos_q   <= fin_pos;
		end
	end

endmodule

[rtl/core/sorted_table_binary_search.sv]
// Sorted table binary search, top level.
// Requests arrive on req (valid/ready). A write request (req_type 0) stores
// value at position and gives no response; positions past the table are
// dropped. A search request (req_type 1) bisects positions 0 ..
// entries_in_use-1 (capped at 1024 entries) for value and gives one response
// on rsp: found and match_position (zero when not found).
// A search makes at most ceil(log2(entries_in_use+1)) probes: 11 for 1024
// entries. Each probe is one read of the single-port table RAM, and the next
// address is picked from the compare in the same cycle. The result of the
// last probe is loaded into the output register and then shown on rsp.
// The response sits in an output register, so the next request is taken
// while a response waits; if rsp stays stalled and a second search finishes,
// the sequencer holds that result and stops taking requests until the
// output register drains.
// Reset clears the control state and the output valid flag and sets
// entries_in_use to 1024; table contents are undefined until written.
// entries_in_use is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Depends on sbs_pkg, sbs_if, sbs_table_ram and sbs_ctrl.
module sorted_table_binary_search import sbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sbs_req_if.sink              req,
	sbs_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [ENTRIES_W-1:0] cfg_wdata
);

	logic [ENTRIES_W-1:0] entries_q;
	logic                 out_valid_q;
	logic                 out_found_q;
	logic [POS_W-1:0]     out_pos_q;
	logic                 slot_free;
	sbs_result_t          res;
	logic                 ram_we;
	logic [TBL_AW-1:0]    ram_addr;
	logic [VALUE_W-1:0]   ram_wdata;
	logic [VALUE_W-1:0]   ram_rdata;

	// Entries-in-use register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (cfg_we) begin
			entries_q <= cfg_wdata;
		end
	end

	sbs_table_ram #(
		.DATA_W (VALUE_W),
		.ADDR_W (TBL_AW),
		.DEPTH  (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	sbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.entries   (entries_q),
		.slot_free (slot_free),
		.res       (res),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	assign slot_free = !out_valid_q || rsp.ready;

	// Output register: load a finished search, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && res.valid) begin
			out_found_q <= res.found;
			out_pos_q   <= res.pos;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.found          = out_found_q;
	assign rsp.match_position = out_pos_q;

endmodule

[rtl/core/sbs_checker.sv]
// Port-level checker for the sorted table search block, bound to the top.
// Depends on sbs_pkg and the assertion macros header.
`include "sorted_table_binary_search_assert.svh"

module sbs_checker import sbs_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_type,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             rsp_found,
	input logic [POS_W-1:0] rsp_match_position
);

	logic req_fire;
	logic rsp_stall;

	assign req_fire  = req_valid && req_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;

	// Hold a stalled response
	`SBS_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_found) && $stable(rsp_match_position))

	// A miss reports position zero
	`SBS_ASSERT_IMP(a_miss_pos_zero, rsp_valid && !rsp_found, rsp_match_position == '0)

	// A write request never raises a response by itself
	`SBS_ASSERT_NXT(a_write_silent, req_fire && (req_type == REQ_WRITE) && !rsp_valid, !rsp_valid)

	// A fresh response leaves the request side open
	`SBS_ASSERT_IMP(a_rsp_rise_ready, $rose(rsp_valid), req_ready)

endmodule

bind sorted_table_binary_search sbs_checker u_sbs_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.req_type           (req.req_type),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_found          (rsp.found),
	.rsp_match_position (rsp.match_position)
);

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for sorted_table_binary_search: table fill, directed lookups, random phases.
// Depends on sbs_pkg, the sbs_req_if/sbs_rsp_if interfaces and the block's RTL.
module tb_top;
	import sbs_pkg::*;

	localparam logic signed [VALUE_W-1:0] V_MIN  = 64'sh8000_0000_0000_0000;
	localparam logic signed [VALUE_W-1:0] V_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VALUE_W-1:0] V_STEP = 64'sh0040_0000_0000_0000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 600;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} lookup_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_WRITE,
		ROW_SEARCH
	} row_kind_t;

	typedef struct packed {
		row_kind_t           kind;
		logic [POS_W-1:0]    position;
		logic [VALUE_W-1:0]  value;
		bit                  typed;
		logic                exp_found;
		logic [POS_W-1:0]    exp_pos;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ENTRIES_W-1:0] cfg_wdata;

	sbs_req_if req_ch ();
	sbs_rsp_if rsp_ch ();

	sorted_table_binary_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the table and the search span
	logic signed [VALUE_W-1:0] entry_copy [TABLE_DEPTH];
	logic [ENTRIES_W-1:0]      span_cfg;
	lookup_t                   pending_lookups [$];
	int                        miss_count;
	bit                        burst;

	// Span changes, writes and lookups after the fill; typed where the answer is plain
	dir_row_t directed_rows [23] = '{
		'{ROW_SEARCH, 10'd0,    V_MIN + 511 * V_STEP, 1'b1, 1'b1, 10'd511},
		'{ROW_SEARCH, 10'd1023, V_MIN,                1'b1, 1'b1, 10'd0},
		'{ROW_SEARCH, 10'h2AA,  V_MAX,                1'b1, 1'b1, 10'd1023},
		'{ROW_SEARCH, 10'h155,  V_MIN + 1,            1'b1, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd7,    64'sd1,               1'b0, 1'b0, 10'd0},
		// span above the table depth saturates
		'{ROW_CFG,    10'd0,    64'd2047,             1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd3,    V_MAX,                1'b1, 1'b1, 10'd1023},
		'{ROW_SEARCH, 10'd9,    V_MIN + 700 * V_STEP + 5, 1'b0, 1'b0, 10'd0},
		// empty span never finds anything
		'{ROW_CFG,    10'd0,    64'd0,                1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0,    V_MIN,                1'b1, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd1,    V_MAX,                1'b1, 1'b0, 10'd0},
		'{ROW_CFG,    10'd0,    64'd1,                1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd512,  V_MIN,                1'b1, 1'b1, 10'd0},
		'{ROW_SEARCH, 10'd513,  V_MAX,                1'b1, 1'b0, 10'd0},
		// unsorted entries and duplicates
		'{ROW_CFG,    10'd0,    64'd3,                1'b0, 1'b0, 10'd0},
		'{ROW_WRITE,  10'd1,    V_MAX,                1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0,    V_MIN + 2 * V_STEP,   1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0,    V_MAX,                1'b1, 1'b1, 10'd1},
		'{ROW_WRITE,  10'd2,    V_MIN,                1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0,    V_MIN,                1'b0, 1'b0, 10'd0},
		'{ROW_CFG,    10'd0,    64'd1024,             1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0,    V_MIN + 900 * V_STEP, 1'b0, 1'b0, 10'd0},
		'{ROW_SEARCH, 10'd0,    -64'sd1,              1'b0, 1'b0, 10'd0}
	};

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Idle length: mostly none or short, a few long
	function automatic int idle_len();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Bisect the shadow table for key within the configured span
	function automatic lookup_t bisect_table(input logic signed [VALUE_W-1:0] key);
		lookup_t res;
		int lo;
		int hi;
		int mid;
		res = '0;
		lo = 0;
		hi = ((span_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(span_cfg)) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (entry_copy[mid] == key) begin
				res.found = 1'b1;
				res.pos = POS_W'(mid);
				break;
			end else if (entry_copy[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid - 1;
			end
		end
		return res;
	endfunction

	task automatic report_error(input string msg);
		if (miss_count < 10)
			$display("[%0t] ERROR: %s", $realtime, msg);
		miss_count++;
	endtask

	// Send one request after a random gap; update the shadow or queue the answer
	task automatic issue_request(input sbs_req_type_t rtype, input logic [POS_W-1:0] pos,
			input logic signed [VALUE_W-1:0] val, input bit typed, input lookup_t typed_res);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.position <= pos;
		req_ch.value    <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (rtype == REQ_WRITE)
			entry_copy[pos] = val;
		else
			pending_lookups.push_back(typed ? typed_res : bisect_table(val));
	endtask

	// Drain, let the block settle, then write the search span
	task automatic set_span(input logic [ENTRIES_W-1:0] n);
		req_ch.valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we   <= 1'b0;
		span_cfg = n;
	endtask

	// Response sink: random stalls unless in a burst stretch
	initial begin : rsp_sink
		int hold;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!burst && $urandom_range(0, 2) == 0) begin
				rsp_ch.ready <= 1'b0;
				hold = idle_len();
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted response with the oldest expected lookup
	always @(posedge clk) begin : rsp_check
		lookup_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_lookups.size() == 0) begin
				report_error($sformatf("response with no search waiting: found=%0b pos=%0d",
					rsp_ch.found, rsp_ch.match_position));
			end else begin
				want = pending_lookups.pop_front();
				if (rsp_ch.found !== want.found || rsp_ch.match_position !== want.pos)
					report_error($sformatf("expected found=%0b pos=%0d, got found=%0b pos=%0d",
						want.found, want.pos, rsp_ch.found, rsp_ch.match_position));
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int rand_items;
		int n_eff;
		int fill_len;
		int searches;
		int r;
		int idx;
		bit wide;
		logic [ENTRIES_W-1:0] n;
		logic signed [VALUE_W-1:0] cur;
		logic signed [VALUE_W-1:0] key;
		lookup_t typed_res;

		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= '0;
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_WRITE;
		req_ch.position <= '0;
		req_ch.value    <= '0;
		burst = 1'b0;
		miss_count = 0;
		rand_items = 0;
		span_cfg = ENTRIES_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Fill every position in ascending order, minimum first and maximum last
		for (int i = 0; i < TABLE_DEPTH; i++)
			issue_request(REQ_WRITE, POS_W'(i),
				(i == TABLE_DEPTH - 1) ? V_MAX : V_MIN + i * V_STEP, 1'b0, '0);

		// Directed rows, starting from the reset span
		foreach (directed_rows[i]) begin
			typed_res.found = directed_rows[i].exp_found;
			typed_res.pos   = directed_rows[i].exp_pos;
			case (directed_rows[i].kind)
				ROW_CFG: set_span(directed_rows[i].value[ENTRIES_W-1:0]);
				ROW_WRITE: issue_request(REQ_WRITE, directed_rows[i].position,
					directed_rows[i].value, 1'b0, '0);
				default: issue_request(REQ_SEARCH, directed_rows[i].position,
					directed_rows[i].value, directed_rows[i].typed, typed_res);
			endcase
		end

		// Random phases: new span, sorted prefix with random content, then lookups
		while (rand_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			case (r)
				0: n = 0;
				1: n = 2047;
				2: n = 1024;
				3: n = ENTRIES_W'($urandom_range(65, 1023));
				4: n = 1;
				5: n = ENTRIES_W'($urandom_range(0, 2047));
				default: n = ENTRIES_W'($urandom_range(2, 40));
			endcase
			burst = 1'b0;
			set_span(n);
			burst = ($urandom_range(0, 3) == 0);
			n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
			fill_len = (n_eff > 64) ? 64 : n_eff;
			wide = (n_eff <= 64);

			// Rewrite the prefix in ascending order; wide gaps span the value range
			cur = V_MIN;
			if (wide && $urandom_range(0, 3) != 0)
				cur = V_MIN + ({$urandom, $urandom} >> 2);
			for (int j = 0; j < fill_len; j++) begin
				issue_request(REQ_WRITE, POS_W'(j), cur, 1'b0, '0);
				rand_items++;
				if (j == fill_len - 2 && $urandom_range(0, 3) == 0)
					cur = V_MAX;
				else if (wide)
					cur = cur + ({$urandom, $urandom} >> $urandom_range(7, 40));
				else
					cur = cur + VALUE_W'($urandom_range(0, 1000));
			end

			// Lookups, with a stray write now and then
			searches = $urandom_range(4, 24);
			for (int s = 0; s < searches; s++) begin
				if ($urandom_range(0, 11) == 0) begin
					issue_request(REQ_WRITE, POS_W'($urandom_range(0, TABLE_DEPTH - 1)),
						{$urandom, $urandom}, 1'b0, '0);
					rand_items++;
				end
				r = $urandom_range(0, 9);
				idx = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
				if (n_eff == 0 || r == 9)
					key = {$urandom, $urandom};
				else if (r < 6)
					key = entry_copy[idx];
				else if (r < 8)
					key = entry_copy[idx] + (($urandom_range(0, 1) == 0) ? 64'sd1 : -64'sd1);
				else
					key = ($urandom_range(0, 1) == 0) ? V_MIN : V_MAX;
				issue_request(REQ_SEARCH, POS_W'($urandom_range(0, TABLE_DEPTH - 1)), key,
					1'b0, '0);
				rand_items++;
			end
		end

		// Drain and let late responses show up
		req_ch.valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (miss_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
